// ----- design/gas_pkg.sv -----
// Shared types and constants of the grid A* search block.
// No dependencies; the interfaces and the top level import it.
package gas_pkg;

  localparam int unsigned COORD_PORT_W = 4;
  localparam int unsigned COST_W       = 9;
  localparam int unsigned F_W          = COST_W + 1;
  localparam int unsigned EXP_W        = 4;

  localparam logic [COST_W-1:0] COST_MAX = '1;
  localparam logic [EXP_W-1:0]  EXP_RESET = 4'd4;

  // Result status codes
  localparam logic [1:0] STAT_RUN    = 2'd0;
  localparam logic [1:0] STAT_PATH   = 2'd1;
  localparam logic [1:0] STAT_NOPATH = 2'd2;

  // Cell marks
  localparam logic [1:0] MARK_NONE   = 2'd0;
  localparam logic [1:0] MARK_OPEN   = 2'd1;
  localparam logic [1:0] MARK_CLOSED = 2'd2;

  // Step from parent to child
  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

endpackage

// ----- design/gas_if.sv -----
// Valid/ready channel interfaces for search requests and results.
// Depends on gas_pkg for the field widths.
interface gas_in_if import gas_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [COORD_PORT_W-1:0] start_x;
  logic [COORD_PORT_W-1:0] start_y;
  logic [COORD_PORT_W-1:0] goal_x;
  logic [COORD_PORT_W-1:0] goal_y;

  modport source (output valid, start_x, start_y, goal_x, goal_y, input ready);
  modport sink   (input valid, start_x, start_y, goal_x, goal_y, output ready);
endinterface

interface gas_out_if import gas_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic [COORD_PORT_W-1:0] path_x;
  logic [COORD_PORT_W-1:0] path_y;
  logic                    last;

  modport source (output valid, status, path_x, path_y, last, input ready);
  modport sink   (input valid, status, path_x, path_y, last, output ready);
endinterface

// ----- design/grid_astar_search_top.sv -----
// Four-neighbour A* search engine on an open square grid.
// Depends on gas_pkg and the channel interfaces in gas_if.sv.
//
// Usage: each request beat on in_i runs up to expansions_per_request
// expansions of one search. A request while no search is active clears the
// cell marks and opens the start cell first; later requests continue the
// same search. Results leave on out_o: one status-0 beat while searching,
// one status-2 beat when the open list empties, or the path cells from goal
// to start with status 1. last marks the final beat of each request.
// The configuration register is written by cfg_we_i/cfg_wdata_i.
// Sequence: a new search first sweeps every entry of the mark memory clear,
// then opens the start cell. Each expansion scans the open list with the shared
// F adder/compare (S_SC_ORD, S_SC_COST, S_SC_CMP per entry) over memories with
// one write port and one registered read port, compacts the list (S_RM_RD and
// S_RM_WR per entry after the taken one), and visits the four neighbours
// (S_NB_RD then S_NB_DEC; only S_NB_RD for a neighbour off the grid).
// A path beat passes S_PATH_RD and S_PATH_EV, then waits in S_OUT for the receiver.
// One request is in work at a time; in_i.ready is high only when idle.
// A stalled receiver holds the result register and the sequencer.
// Reset clears the sequencer, the search state and the register (to 4).
module grid_astar_search_top import gas_pkg::*; #(
  parameter int unsigned GRID_SIDE = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  gas_in_if.sink           in_i,
  gas_out_if.source        out_o,
  input  logic             cfg_we_i,
  input  logic [EXP_W-1:0] cfg_wdata_i
);

  localparam int unsigned COORD_W = (GRID_SIDE > 2) ? $clog2(GRID_SIDE) : 1;
  localparam int unsigned CELL_W  = 2 * COORD_W;
  localparam int unsigned CELLS   = GRID_SIDE * GRID_SIDE;
  localparam int unsigned ORD_W   = $clog2(CELLS);
  localparam int unsigned CNT_W   = $clog2(CELLS + 1);
  localparam int unsigned LIMIT   = 2 * GRID_SIDE - 1;
  localparam int unsigned K_W     = $clog2(2 * GRID_SIDE);
  localparam logic [COORD_W-1:0] CMAX = COORD_W'(GRID_SIDE - 1);

  typedef enum logic [14:0] {
    S_IDLE    = 15'h0001,
    S_CLR     = 15'h0002,
    S_INIT    = 15'h0004,
    S_CHK     = 15'h0008,
    S_SC_ORD  = 15'h0010,
    S_SC_COST = 15'h0020,
    S_SC_CMP  = 15'h0040,
    S_RM_RD   = 15'h0080,
    S_RM_WR   = 15'h0100,
    S_CLOSE   = 15'h0200,
    S_NB_RD   = 15'h0400,
    S_NB_DEC  = 15'h0800,
    S_PATH_RD = 15'h1000,
    S_PATH_EV = 15'h2000,
    S_OUT     = 15'h4000
  } state_e;

  function automatic logic [COORD_W-1:0] clamp(input logic [COORD_PORT_W-1:0] v);
    logic [COORD_W+COORD_PORT_W-1:0] ext;
    ext = {{COORD_W{1'b0}}, v};
    if (ext >= (COORD_W+COORD_PORT_W)'(GRID_SIDE)) return CMAX;
    return ext[COORD_W-1:0];
  endfunction

  function automatic logic [COORD_W-1:0] adiff(input logic [COORD_W-1:0] a,
                                                input logic [COORD_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [COORD_PORT_W-1:0] to_port(input logic [COORD_W-1:0] v);
    logic [COORD_W+COORD_PORT_W-1:0] ext;
    ext = {{COORD_PORT_W{1'b0}}, v};
    return ext[COORD_PORT_W-1:0];
  endfunction

  // Memories
  logic [1:0]        mark_mem [2**CELL_W];
  logic [COST_W-1:0] cost_mem [2**CELL_W];
  logic [1:0]        from_mem [2**CELL_W];
  logic [CELL_W-1:0] ord_mem  [2**ORD_W];

  logic              mark_we, cost_we, from_we, ord_we;
  logic [CELL_W-1:0] mark_wa, cost_wa, from_wa, mark_ra, cost_ra, from_ra;
  logic [ORD_W-1:0]  ord_wa, ord_ra;
  logic [1:0]        mark_wd, from_wd, mark_rd, from_rd;
  logic [COST_W-1:0] cost_wd, cost_rd;
  logic [CELL_W-1:0] ord_wd, ord_rd;

  always_ff @(posedge clk_i) begin
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    mark_rd <= mark_mem[mark_ra];
  end
  always_ff @(posedge clk_i) begin
    if (cost_we) cost_mem[cost_wa] <= cost_wd;
    cost_rd <= cost_mem[cost_ra];
  end
  always_ff @(posedge clk_i) begin
    if (from_we) from_mem[from_wa] <= from_wd;
    from_rd <= from_mem[from_ra];
  end
  always_ff @(posedge clk_i) begin
    if (ord_we) ord_mem[ord_wa] <= ord_wd;
    ord_rd <= ord_mem[ord_ra];
  end

  // Control and datapath registers
  state_e            state_q, state_d;
  logic              active_q, active_d;
  logic [EXP_W-1:0]  epr_q;
  logic [EXP_W-1:0]  n_q, n_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  i_q, i_d;
  logic [CNT_W-1:0]  best_i_q, best_i_d;
  logic [CELL_W-1:0] addr_q, addr_d;
  logic [CELL_W-1:0] start_q, start_d, goal_q, goal_d;
  logic [CELL_W-1:0] cand_q, cand_d, best_q, best_d, pc_q, pc_d;
  logic [COST_W-1:0] bcost_q, bcost_d, g_q, g_d;
  logic [F_W-1:0]    bestf_q, bestf_d;
  logic [1:0]        dir_q, dir_d;
  logic [K_W-1:0]    k_q, k_d;
  logic              more_q, more_d;
  logic [1:0]        st_q, st_d;
  logic [COORD_W-1:0] px_q, px_d, py_q, py_d;
  logic              last_q, last_d;

  logic              in_acc;
  logic [F_W-1:0]    f_val;
  logic [COORD_W-1:0] cx, cy, gx, gy, bx, by, nx, ny, wx, wy;
  logic              nb_ok, at_start;

  assign in_acc      = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = (state_q == S_OUT);
  assign out_o.status = st_q;
  assign out_o.path_x = to_port(px_q);
  assign out_o.path_y = to_port(py_q);
  assign out_o.last   = last_q;

  // Shared F unit: cost plus Manhattan estimate of the scanned cell
  assign cx    = cand_q[COORD_W-1:0];
  assign cy    = cand_q[CELL_W-1:COORD_W];
  assign gx    = goal_q[COORD_W-1:0];
  assign gy    = goal_q[CELL_W-1:COORD_W];
  assign f_val = F_W'(cost_rd) + F_W'(adiff(cx, gx)) + F_W'(adiff(cy, gy));

  // Neighbour of the expanded cell for the current direction
  assign bx = best_q[COORD_W-1:0];
  assign by = best_q[CELL_W-1:COORD_W];
  always_comb begin
    nx = bx;
    ny = by;
    nb_ok = 1'b0;
    case (dir_q)
      DIR_RIGHT: begin nx = bx + 1'b1; nb_ok = (bx != CMAX); end
      DIR_LEFT:  begin nx = bx - 1'b1; nb_ok = (bx != '0);   end
      DIR_UP:    begin ny = by + 1'b1; nb_ok = (by != CMAX); end
      default:   begin ny = by - 1'b1; nb_ok = (by != '0);   end
    endcase
  end

  // Path walk: current cell and the end-of-walk test
  assign wx = pc_q[COORD_W-1:0];
  assign wy = pc_q[CELL_W-1:COORD_W];
  assign at_start = (cost_rd == '0) || ((32'(k_q) + 32'd1) >= 32'(LIMIT));

  // Sequencer
  always_comb begin
    logic [COORD_W-1:0] tx, ty;
    tx = wx;
    ty = wy;
    state_d  = state_q;
    active_d = active_q;
    n_d      = n_q;
    cnt_d    = cnt_q;
    i_d      = i_q;
    best_i_d = best_i_q;
    addr_d   = addr_q;
    start_d  = start_q;
    goal_d   = goal_q;
    cand_d   = cand_q;
    best_d   = best_q;
    pc_d     = pc_q;
    bcost_d  = bcost_q;
    g_d      = g_q;
    bestf_d  = bestf_q;
    dir_d    = dir_q;
    k_d      = k_q;
    more_d   = more_q;
    st_d     = st_q;
    px_d     = px_q;
    py_d     = py_q;
    last_d   = last_q;
    mark_we = 1'b0; mark_wa = addr_q; mark_wd = MARK_NONE; mark_ra = {ny, nx};
    cost_we = 1'b0; cost_wa = {ny, nx}; cost_wd = g_q; cost_ra = {ny, nx};
    from_we = 1'b0; from_wa = {ny, nx}; from_wd = dir_q; from_ra = pc_q;
    ord_we  = 1'b0; ord_wa = cnt_q[ORD_W-1:0]; ord_wd = {ny, nx};
    ord_ra  = i_q[ORD_W-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          n_d = '0;
          if (!active_q) begin
            start_d = {clamp(in_i.start_y), clamp(in_i.start_x)};
            goal_d  = {clamp(in_i.goal_y), clamp(in_i.goal_x)};
            addr_d  = '0;
            state_d = S_CLR;
          end else begin
            state_d = S_CHK;
          end
        end
      end
      // Sweep the mark memory clear
      S_CLR: begin
        mark_we = 1'b1;
        addr_d  = addr_q + 1'b1;
        if (addr_q == '1) state_d = S_INIT;
      end
      // Open the start cell
      S_INIT: begin
        mark_we = 1'b1; mark_wa = start_q; mark_wd = MARK_OPEN;
        cost_we = 1'b1; cost_wa = start_q; cost_wd = '0;
        ord_we  = 1'b1; ord_wa = '0; ord_wd = start_q;
        cnt_d    = CNT_W'(1);
        active_d = 1'b1;
        state_d  = S_CHK;
      end
      S_CHK: begin
        px_d = '0; py_d = '0; last_d = 1'b1; more_d = 1'b0;
        if (n_q == epr_q) begin
          st_d = STAT_RUN;
          state_d = S_OUT;
        end else if (cnt_q == '0) begin
          active_d = 1'b0;
          st_d = STAT_NOPATH;
          state_d = S_OUT;
        end else begin
          i_d = '0;
          state_d = S_SC_ORD;
        end
      end
      S_SC_ORD: state_d = S_SC_COST;
      S_SC_COST: begin
        cost_ra = ord_rd;
        cand_d  = ord_rd;
        state_d = S_SC_CMP;
      end
      // Keep the earliest entry of least F
      S_SC_CMP: begin
        if (i_q == '0 || f_val < bestf_q) begin
          bestf_d  = f_val;
          best_i_d = i_q;
          best_d   = cand_q;
          bcost_d  = cost_rd;
        end
        if (i_q + 1'b1 == cnt_q) begin
          i_d = (i_q == '0 || f_val < bestf_q) ? i_q : best_i_q;
          state_d = S_RM_RD;
        end else begin
          i_d = i_q + 1'b1;
          state_d = S_SC_ORD;
        end
      end
      // Close the gap left by the taken entry
      S_RM_RD: begin
        ord_ra = ORD_W'(i_q + 1'b1);
        if (i_q + 1'b1 < cnt_q) begin
          state_d = S_RM_WR;
        end else begin
          cnt_d = cnt_q - 1'b1;
          state_d = S_CLOSE;
        end
      end
      S_RM_WR: begin
        ord_we = 1'b1; ord_wa = i_q[ORD_W-1:0]; ord_wd = ord_rd;
        i_d = i_q + 1'b1;
        state_d = S_RM_RD;
      end
      S_CLOSE: begin
        mark_we = 1'b1; mark_wa = best_q; mark_wd = MARK_CLOSED;
        if (best_q == goal_q) begin
          active_d = 1'b0;
          cnt_d = '0;
          pc_d = best_q;
          k_d = '0;
          state_d = S_PATH_RD;
        end else begin
          g_d = (bcost_q == COST_MAX) ? COST_MAX : bcost_q + 1'b1;
          dir_d = DIR_RIGHT;
          state_d = S_NB_RD;
        end
      end
      S_NB_RD: begin
        if (nb_ok) begin
          state_d = S_NB_DEC;
        end else if (dir_q == DIR_DOWN) begin
          n_d = n_q + 1'b1;
          state_d = S_CHK;
        end else begin
          dir_d = dir_q + 1'b1;
        end
      end
      // Open or relax the neighbour
      S_NB_DEC: begin
        if (mark_rd == MARK_OPEN) begin
          if (g_q < cost_rd) begin
            cost_we = 1'b1;
            from_we = 1'b1;
          end
        end else if (mark_rd != MARK_CLOSED && cnt_q < CNT_W'(CELLS)) begin
          mark_we = 1'b1; mark_wa = {ny, nx}; mark_wd = MARK_OPEN;
          cost_we = 1'b1;
          from_we = 1'b1;
          ord_we  = 1'b1;
          cnt_d   = cnt_q + 1'b1;
        end
        if (dir_q == DIR_DOWN) begin
          n_d = n_q + 1'b1;
          state_d = S_CHK;
        end else begin
          dir_d = dir_q + 1'b1;
          state_d = S_NB_RD;
        end
      end
      S_PATH_RD: begin
        cost_ra = pc_q;
        state_d = S_PATH_EV;
      end
      // Emit the path cell and step to its parent
      S_PATH_EV: begin
        st_d = STAT_PATH;
        px_d = wx; py_d = wy;
        last_d = at_start;
        more_d = !at_start;
        k_d = k_q + 1'b1;
        case (from_rd)
          DIR_RIGHT: tx = (wx != '0) ? wx - 1'b1 : wx;
          DIR_LEFT:  tx = (wx != CMAX) ? wx + 1'b1 : wx;
          DIR_UP:    ty = (wy != '0) ? wy - 1'b1 : wy;
          default:   ty = (wy != CMAX) ? wy + 1'b1 : wy;
        endcase
        pc_d = {ty, tx};
        state_d = S_OUT;
      end
      // Hold the result beat until taken
      S_OUT: begin
        if (out_o.ready) state_d = more_q ? S_PATH_RD : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      active_q <= 1'b0;
      cnt_q    <= '0;
      goal_q   <= '0;
      epr_q    <= EXP_RESET;
      more_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      cnt_q    <= cnt_d;
      goal_q   <= goal_d;
      more_q   <= more_d;
      if (cfg_we_i) epr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    i_q      <= i_d;
    best_i_q <= best_i_d;
    addr_q   <= addr_d;
    start_q  <= start_d;
    cand_q   <= cand_d;
    best_q   <= best_d;
    pc_q     <= pc_d;
    bcost_q  <= bcost_d;
    g_q      <= g_d;
    bestf_q  <= bestf_d;
    dir_q    <= dir_d;
    k_q      <= k_d;
    st_q     <= st_d;
    px_q     <= px_d;
    py_q     <= py_d;
    last_q   <= last_d;
  end

`ifndef SYNTHESIS
  a_no_accept_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready) else $error("request taken while result pending");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CELLS)) else $error("open list overflow");
  a_new_search_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !active_q) |=> (state_q == S_CLR)) else $error("new search without clear");
  a_zero_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status != STAT_PATH) |-> (out_o.path_x == '0 && out_o.path_y == '0
      && out_o.last)) else $error("status beat with cell or without last");
`endif

endmodule

// ----- bench/tb_grid_astar_search_top.sv -----
// Self-checking bench for grid_astar_search_top: directed table, then random searches.
// Depends on gas_pkg, gas_if.sv and the top level; an A* predictor checks untyped rows.
module tb_grid_astar_search_top;
  import gas_pkg::*;

  localparam int SIDE       = 16;
  localparam int CELLS      = SIDE * SIDE;
  localparam int PATH_MAX   = 2 * SIDE - 1;
  localparam int N_RANDOM   = 300;
  localparam int N_ROWS     = 20;
  localparam int PEND_DEPTH = 64;
  localparam int CYCLE_CAP  = 40000000;
  localparam int DRAIN      = 40;

  typedef struct packed {
    logic [1:0]              status;
    logic [COORD_PORT_W-1:0] x;
    logic [COORD_PORT_W-1:0] y;
    logic                    last;
  } beat_t;

  typedef struct {
    int                      cfg;   // -1 keeps the current register value
    logic [COORD_PORT_W-1:0] sx, sy, gx, gy;
    bit                      typed;
    beat_t                   want;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [EXP_W-1:0] cfg_wdata_i;

  gas_in_if  in_bus ();
  gas_out_if out_bus ();

  grid_astar_search_top #(.GRID_SIDE(SIDE)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_bus),
    .out_o      (out_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Predictor state
  logic [1:0]        cell_state [CELLS];
  logic [COST_W-1:0] cell_g     [CELLS];
  logic [1:0]        cell_dir   [CELLS];
  int                open_list  [CELLS];
  int                open_len;
  bit                searching;
  int                goal_cell;
  logic [EXP_W-1:0]  exp_per_req;

  // Beats of the latest request, and the ring of beats still to arrive
  beat_t new_beats [PATH_MAX + 1];
  int    new_cnt;
  beat_t pend_buf [PEND_DEPTH];
  int    pushed_n = 0;
  int    popped_n = 0;
  int    mismatches = 0;
  int    cycles = 0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int manhattan(input int c);
    int dx, dy;
    dx = (c % SIDE) - (goal_cell % SIDE);
    dy = (c / SIDE) - (goal_cell / SIDE);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return dx + dy;
  endfunction

  task automatic add_beat(input beat_t b);
    new_beats[new_cnt] = b;
    new_cnt++;
  endtask

  task automatic queue_beat(input beat_t b);
    pend_buf[pushed_n % PEND_DEPTH] = b;
    pushed_n++;
  endtask

  task automatic probe_cell(input int c, input int g, input logic [1:0] dir);
    if (cell_state[c] == MARK_CLOSED) return;
    if (cell_state[c] == MARK_OPEN) begin
      if (g < cell_g[c]) begin
        cell_g[c]   = COST_W'(g);
        cell_dir[c] = dir;
      end
      return;
    end
    if (open_len >= CELLS) return;
    cell_state[c] = MARK_OPEN;
    cell_g[c]     = COST_W'(g);
    cell_dir[c]   = dir;
    open_list[open_len] = c;
    open_len++;
  endtask

  // Work out the beats that one accepted request gives; they land in new_beats
  task automatic search_step(input logic [3:0] sx, sy, gx, gy);
    int i, n, best, bestf, f, cur, cx, cy, g, c, k, px, py;
    bit at_start;
    new_cnt = 0;
    if (!searching) begin
      for (i = 0; i < CELLS; i++) cell_state[i] = MARK_NONE;
      cur = sy * SIDE + sx;
      goal_cell = gy * SIDE + gx;
      cell_state[cur] = MARK_OPEN;
      cell_g[cur] = '0;
      open_list[0] = cur;
      open_len = 1;
      searching = 1'b1;
    end
    for (n = 0; n < exp_per_req; n++) begin
      if (open_len == 0) begin
        searching = 1'b0;
        add_beat('{STAT_NOPATH, 4'd0, 4'd0, 1'b1});
        return;
      end
      best = 0;
      bestf = 0;
      for (i = 0; i < open_len; i++) begin
        f = cell_g[open_list[i]] + manhattan(open_list[i]);
        if (i == 0 || f < bestf) begin
          bestf = f;
          best = i;
        end
      end
      cur = open_list[best];
      for (i = best; i + 1 < open_len; i++) open_list[i] = open_list[i + 1];
      open_len--;
      cell_state[cur] = MARK_CLOSED;
      // Goal taken: walk parents back to the start
      if (cur == goal_cell) begin
        searching = 1'b0;
        open_len = 0;
        c = cur;
        k = 0;
        while (1) begin
          px = c % SIDE;
          py = c / SIDE;
          at_start = (cell_g[c] == 0) || (k + 1 >= PATH_MAX);
          add_beat('{STAT_PATH, px[3:0], py[3:0], at_start});
          k++;
          if (at_start) return;
          case (cell_dir[c])
            DIR_RIGHT: px = (px > 0) ? px - 1 : 0;
            DIR_LEFT:  px = (px + 1 < SIDE) ? px + 1 : px;
            DIR_UP:    py = (py > 0) ? py - 1 : 0;
            default:   py = (py + 1 < SIDE) ? py + 1 : py;
          endcase
          c = py * SIDE + px;
        end
      end
      cx = cur % SIDE;
      cy = cur / SIDE;
      g = cell_g[cur] + 1;
      if (g > COST_MAX) g = COST_MAX;
      if (cx + 1 < SIDE) probe_cell(cur + 1, g, DIR_RIGHT);
      if (cx > 0)        probe_cell(cur - 1, g, DIR_LEFT);
      if (cy + 1 < SIDE) probe_cell(cur + SIDE, g, DIR_UP);
      if (cy > 0)        probe_cell(cur - SIDE, g, DIR_DOWN);
    end
    add_beat('{STAT_RUN, 4'd0, 4'd0, 1'b1});
  endtask

  // Receiver: ready follows one of four stall modes, picked at random
  int stall_mode;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      stall_mode    <= 0;
    end else begin
      if (cycles % 64 == 0) stall_mode <= int'($urandom_range(0, 3));
      case (stall_mode)
        0:       out_bus.ready <= 1'b1;
        1:       out_bus.ready <= ($urandom_range(0, 1) == 0);
        2:       out_bus.ready <= ($urandom_range(0, 3) == 0);
        default: out_bus.ready <= (cycles % 8) < 5;
      endcase
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    beat_t got, want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got = '{out_bus.status, out_bus.path_x, out_bus.path_y, out_bus.last};
      if (pushed_n == popped_n) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: status %0d x %0d y %0d last %0d",
                   got.status, got.x, got.y, got.last);
      end else begin
        want = pend_buf[popped_n % PEND_DEPTH];
        popped_n++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat mismatch: exp status %0d x %0d y %0d last %0d, got %0d %0d %0d %0d",
                     want.status, want.x, want.y, want.last,
                     got.status, got.x, got.y, got.last);
        end
      end
    end
  end

  // Hold valid until the beat is taken, then queue its expected results
  task automatic send_request(input logic [3:0] sx, sy, gx, gy, input bit typed,
                              input beat_t want);
    in_bus.valid   <= 1'b1;
    in_bus.start_x <= sx;
    in_bus.start_y <= sy;
    in_bus.goal_x  <= gx;
    in_bus.goal_y  <= gy;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    search_step(sx, sy, gx, gy);
    if (typed) queue_beat(want);
    else for (int i = 0; i < new_cnt; i++) queue_beat(new_beats[i]);
  endtask

  // Drain, then write the register while the block is idle
  task automatic write_expansions(input logic [EXP_W-1:0] val);
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pushed_n != popped_n) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    exp_per_req = val;
  endtask

  function automatic logic [3:0] near(input logic [3:0] v);
    int t;
    t = int'(v) + int'($urandom_range(0, 6)) - 3;
    if (t < 0) t = 0;
    if (t > SIDE - 1) t = SIDE - 1;
    return t[3:0];
  endfunction

  function automatic row_t make_row(input int cfg, input int sx, sy, gx, gy,
                                    input bit typed, input beat_t want);
    row_t r;
    r.cfg   = cfg;
    r.sx    = 4'(sx);
    r.sy    = 4'(sy);
    r.gx    = 4'(gx);
    r.gy    = 4'(gy);
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  row_t  plan [N_ROWS];
  int    burst_left;

  initial begin
    logic [3:0] sx, sy, gx, gy;
    int phase_left, gap, p, np;
    beat_t none;
    none = '0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_bus.valid = 1'b0;
    in_bus.start_x = '0;
    in_bus.start_y = '0;
    in_bus.goal_x = '0;
    in_bus.goal_y = '0;
    searching = 1'b0;
    open_len = 0;
    goal_cell = 0;
    new_cnt = 0;
    exp_per_req = EXP_RESET;
    for (int i = 0; i < CELLS; i++) cell_state[i] = MARK_NONE;

    // Directed table: start on goal, neighbor goal, zero expansions, corner to corner, budgets of 1 and 4
    np = 0;
    plan[np] = make_row(-1, 0, 0, 0, 0, 1'b1, '{STAT_PATH, 4'd0, 4'd0, 1'b1}); np++;
    plan[np] = make_row(-1, 15, 15, 15, 15, 1'b1, '{STAT_PATH, 4'd15, 4'd15, 1'b1}); np++;
    plan[np] = make_row(-1, 5, 5, 6, 5, 1'b0, none); np++;
    plan[np] = make_row(0, 3, 3, 10, 12, 1'b1, '{STAT_RUN, 4'd0, 4'd0, 1'b1}); np++;
    plan[np] = make_row(-1, 9, 9, 9, 9, 1'b1, '{STAT_RUN, 4'd0, 4'd0, 1'b1}); np++;
    plan[np] = make_row(15, 0, 0, 0, 0, 1'b0, none); np++;
    plan[np] = make_row(-1, 0, 0, 0, 0, 1'b0, none); np++;
    for (int r = 0; r < 3; r++) begin
      plan[np] = make_row(-1, 0, 0, 15, 15, 1'b0, none); np++;
    end
    for (int r = 0; r < 3; r++) begin
      plan[np] = make_row(-1, 15, 0, 0, 15, 1'b0, none); np++;
    end
    for (int r = 0; r < 3; r++) begin
      plan[np] = make_row(-1, 0, 15, 15, 0, 1'b0, none); np++;
    end
    plan[np] = make_row(1, 10, 7, 10, 8, 1'b0, none); np++;
    plan[np] = make_row(-1, 10, 7, 10, 8, 1'b0, none); np++;
    plan[np] = make_row(4, 7, 8, 8, 6, 1'b0, none); np++;
    plan[np] = make_row(-1, 7, 8, 8, 6, 1'b0, none); np++;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].cfg >= 0) write_expansions(plan[i].cfg[EXP_W-1:0]);
      send_request(plan[i].sx, plan[i].sy, plan[i].gx, plan[i].gy,
                   plan[i].typed, plan[i].want);
    end

    // Random phases: bursts of requests, each phase with its own expansion count
    phase_left = 0;
    burst_left = 0;
    p = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (phase_left == 0) begin
        case (p)
          0: write_expansions(4'd1);
          1: write_expansions(4'd15);
          2: write_expansions(4'd8);
          3: write_expansions(4'd2);
          default: write_expansions(4'($urandom_range(1, 15)));
        endcase
        p++;
        phase_left = int'($urandom_range(20, 40));
      end
      phase_left--;
      sx = 4'($urandom_range(0, 15));
      sy = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 3) != 0) begin
        gx = near(sx);
        gy = near(sy);
      end else begin
        gx = 4'($urandom_range(0, 15));
        gy = 4'($urandom_range(0, 15));
      end
      send_request(sx, sy, gx, gy, 1'b0, none);
      if (burst_left == 0) begin
        burst_left = int'($urandom_range(1, 8));
        gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 20));
        if (gap > 0) begin
          in_bus.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end else begin
        burst_left--;
      end
    end
    in_bus.valid <= 1'b0;

    // Drain and settle
    while (pushed_n != popped_n) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (mismatches == 0 && pushed_n == popped_n) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
